// ----- design/pcq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcq_pkg
// Shared types and constants for the palette color quantizer.
// ----------------------------------------------------------------------------
package pcq_pkg;

  localparam int unsigned COLOR_W = 32;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned SQ_W    = 2 * CHAN_W;
  localparam int unsigned DIST_W  = SQ_W + 2;   // sum of three squares
  localparam int unsigned GREEN_LSB = 8;
  localparam int unsigned BLUE_LSB  = 16;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned HOW_W   = 2;

  localparam logic [HOW_W-1:0] HOW_EXACT    = 2'd0;
  localparam logic [HOW_W-1:0] HOW_INSERTED = 2'd1;
  localparam logic [HOW_W-1:0] HOW_NEAREST  = 2'd2;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // request state handed from cell to cell
  typedef struct packed {
    logic               valid;
    logic [COLOR_W-1:0] color;
    logic               found;
    logic [DIST_W-1:0]  best_dist;
  } token_t;

  // palette write broadcast to every cell
  typedef struct packed {
    logic               en;
    logic [COLOR_W-1:0] color;
  } wr_t;

  function automatic logic [SQ_W-1:0] diff_sq(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

endpackage

// ----- design/pcq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcq_cell
// One palette slot: holds its color, checks the passing request for an exact
// match and for a closer RGB distance, then hands the request on.
// ----------------------------------------------------------------------------
module pcq_cell #(
  parameter int unsigned IDX_W    = 4,
  parameter int unsigned CNT_W    = 5,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pcq_pkg::token_t      tok_in,
  input  logic [IDX_W-1:0]     slot_in,
  output pcq_pkg::token_t      tok_out,
  output logic [IDX_W-1:0]     slot_out,
  input  logic [CNT_W-1:0]     filled_count,
  input  pcq_pkg::wr_t         wr,
  input  logic [IDX_W-1:0]     wr_slot
);

  logic [pcq_pkg::COLOR_W-1:0] entry;
  logic                        filled;
  logic                        exact;
  logic [pcq_pkg::DIST_W-1:0]  cand_dist;
  logic                        closer;
  logic                        take;

  always_ff @(posedge clk) begin
    if (wr.en && wr_slot == IDX_W'(CELL_IDX)) begin
      entry <= wr.color;
    end
  end

  assign filled = CNT_W'(CELL_IDX) < filled_count;
  assign exact  = filled && (entry == tok_in.color);

  assign cand_dist =
      pcq_pkg::DIST_W'(pcq_pkg::diff_sq(tok_in.color[0 +: pcq_pkg::CHAN_W],
                                        entry[0 +: pcq_pkg::CHAN_W]))
    + pcq_pkg::DIST_W'(pcq_pkg::diff_sq(tok_in.color[pcq_pkg::GREEN_LSB +: pcq_pkg::CHAN_W],
                                        entry[pcq_pkg::GREEN_LSB +: pcq_pkg::CHAN_W]))
    + pcq_pkg::DIST_W'(pcq_pkg::diff_sq(tok_in.color[pcq_pkg::BLUE_LSB +: pcq_pkg::CHAN_W],
                                        entry[pcq_pkg::BLUE_LSB +: pcq_pkg::CHAN_W]));
  assign closer = filled && (cand_dist < tok_in.best_dist);
  // this cell claims an unmatched request on a hit or a strictly closer distance
  assign take   = !tok_in.found && (exact || closer);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.color     <= tok_in.color;
    tok_out.found     <= tok_in.found || exact;
    tok_out.best_dist <= (take && !exact) ? cand_dist : tok_in.best_dist;
    slot_out          <= take ? IDX_W'(CELL_IDX) : slot_in;
  end

endmodule

// ----- design/palette_color_quantizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_color_quantizer
// Maps RGBA colors to slots of a palette that fills on first use.
// ----------------------------------------------------------------------------
// One request at a time walks a row of SLOT_COUNT cells, one cell per cycle,
// each cell holding one palette color. An accepted request passes the chain
// into the tail register and moves on to the output register once the output
// is free; the next request is taken the cycle after its result has moved to
// the output, so no new color is taken before the last one has left the tail.
// A finished result may wait at the output while the next request runs.
// how_found: 0 exact match, 1 newly inserted, 2 nearest in a full palette.
// slot_index carries the low 4 bits of the slot number.
// ----------------------------------------------------------------------------
module palette_color_quantizer #(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [pcq_pkg::COLOR_W-1:0] color_rgba,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pcq_pkg::SLOT_W-1:0]  slot_index,
  output logic [pcq_pkg::HOW_W-1:0]   how_found
);

  localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);

  pcq_pkg::token_t    tok [SLOT_COUNT+1];
  logic [IDX_W-1:0]   slot_c [SLOT_COUNT+1];

  logic               busy;
  logic [CNT_W-1:0]   filled_count;
  logic               tail_valid;
  logic [pcq_pkg::COLOR_W-1:0] tail_color;
  logic               tail_found;
  logic [IDX_W-1:0]   tail_slot;
  logic               xfer;
  logic               full;
  pcq_pkg::wr_t       wr;
  logic [IDX_W-1:0]   wr_slot;

  assign in_stall = busy;

  assign tok[0].valid     = in_valid && !in_stall;
  assign tok[0].color     = color_rgba;
  assign tok[0].found     = 1'b0;
  assign tok[0].best_dist = pcq_pkg::DIST_MAX;
  assign slot_c[0]        = '0;

  for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_cell
    pcq_cell #(
      .IDX_W   (IDX_W),
      .CNT_W   (CNT_W),
      .CELL_IDX(k)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .tok_in      (tok[k]),
      .slot_in     (slot_c[k]),
      .tok_out     (tok[k+1]),
      .slot_out    (slot_c[k+1]),
      .filled_count(filled_count),
      .wr          (wr),
      .wr_slot     (wr_slot)
    );
  end

  assign full    = filled_count == CNT_W'(SLOT_COUNT);
  assign xfer    = tail_valid && (!out_valid || !out_stall);
  assign wr.en   = xfer && !tail_found && !full;
  assign wr.color = tail_color;
  assign wr_slot = IDX_W'(filled_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      tail_valid   <= 1'b0;
      out_valid    <= 1'b0;
      filled_count <= '0;
    end else begin
      if (tok[0].valid) begin
        busy <= 1'b1;
      end else if (xfer) begin
        busy <= 1'b0;
      end
      if (tok[SLOT_COUNT].valid) begin
        tail_valid <= 1'b1;
      end else if (xfer) begin
        tail_valid <= 1'b0;
      end
      if (xfer) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (wr.en) begin
        filled_count <= filled_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok[SLOT_COUNT].valid) begin
      tail_color <= tok[SLOT_COUNT].color;
      tail_found <= tok[SLOT_COUNT].found;
      tail_slot  <= slot_c[SLOT_COUNT];
    end
    if (xfer) begin
      if (tail_found) begin
        slot_index <= pcq_pkg::SLOT_W'(tail_slot);
        how_found  <= pcq_pkg::HOW_EXACT;
      end else if (!full) begin
        slot_index <= pcq_pkg::SLOT_W'(filled_count);
        how_found  <= pcq_pkg::HOW_INSERTED;
      end else begin
        slot_index <= pcq_pkg::SLOT_W'(tail_slot);
        how_found  <= pcq_pkg::HOW_NEAREST;
      end
    end
  end

endmodule
